// File: rtl/rpm_pkg.sv
// Shared types and constants for the regular polygon pixel mask.
// Used by the sine unit, the normal sequencer, the edge cells and the top level.
`default_nettype none

package rpm_pkg;

  // Default number of edge cells in the chain.
  localparam int MaxSidesDefault = 16;

  // Pixels at or beyond these bounds are always outside.
  localparam int ImageWidth  = 4096;
  localparam int ImageHeight = 4096;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_RADIUS   = 3'd2,
    REG_SIDES    = 3'd3,
    REG_ROTATION = 3'd4
  } cfg_reg_e;

  // Odd polynomial for the quarter sine wave, coefficients in Q30.
  localparam logic [30:0] Coef1 = 31'd1686629713;
  localparam logic [30:0] Coef3 = 31'd693598669;
  localparam logic [30:0] Coef5 = 31'd85569304;
  localparam logic [30:0] Coef7 = 31'd5026994;
  localparam logic [30:0] Coef9 = 31'd172273;

  // Sequencer that recomputes the edge normals and the apothem.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_INIT,
    SEQ_EDGE,
    SEQ_COS_WAIT,
    SEQ_SIN_WAIT,
    SEQ_APO,
    SEQ_APO_WAIT,
    SEQ_APO_MUL
  } seq_state_e;

  // Pixel moving down the cell chain: offsets from the center in Q12.4.
  typedef struct packed {
    logic               vld;
    logic               in_poly;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } rpm_pix_t;

  // Normal shifted into the cell chain during a recompute, Q1.15.
  typedef struct packed {
    logic               load;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } rpm_nrm_t;

endpackage

`default_nettype wire

// File: rtl/rpm_sine.sv
// Iterative fixed-point sine of a 16-bit angle, one multiply on every other step.
// Depends on rpm_pkg for the polynomial coefficients.
`default_nettype none

module rpm_sine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        angle_i,
  output logic               done_o,
  output logic signed [15:0] value_o
);
  import rpm_pkg::*;

  localparam logic [3:0] StSquare = 4'd0;
  localparam logic [3:0] StLoadU2 = 4'd1;
  localparam logic [3:0] StFinMul = 4'd10;
  localparam logic [3:0] StLast   = 4'd11;

  logic               run_q;
  logic               done_q;
  logic [3:0]         st_q;
  logic [16:0]        u_q;
  logic               neg_q;
  logic [16:0]        u2_q;
  logic [30:0]        p_q;
  logic [47:0]        prod_q;
  logic signed [15:0] value_q;

  logic [16:0] u_start;
  logic [16:0] op_a;
  logic [30:0] op_b;
  logic [30:0] coef;
  logic [32:0] rnd;
  logic [17:0] mag_full;
  logic [14:0] mag_sat;

  // Fold the angle onto the first quadrant.
  always_comb begin
    u_start = {1'b0, angle_i[13:0], 2'b00};
    if (angle_i[14]) begin
      u_start = 17'd65536 - {1'b0, angle_i[13:0], 2'b00};
    end
  end

  always_comb begin
    op_a = u2_q;
    op_b = p_q;
    if (st_q == StSquare) begin
      op_a = u_q;
      op_b = 31'(u_q);
    end else if (st_q == StFinMul) begin
      op_a = u_q;
    end
  end

  // Horner steps run from the highest coefficient down.
  always_comb begin
    case (st_q[3:1])
      3'd1:    coef = Coef7;
      3'd2:    coef = Coef5;
      3'd3:    coef = Coef3;
      default: coef = Coef1;
    endcase
  end

  always_comb begin
    rnd      = {1'b0, prod_q[47:16]} + 33'd16384;
    mag_full = rnd[32:15];
    mag_sat  = (mag_full > 18'd32767) ? 15'd32767 : mag_full[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      st_q   <= StSquare;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        st_q  <= StSquare;
      end else if (run_q) begin
        if (st_q == StLast) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          st_q <= st_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q   <= u_start;
      neg_q <= angle_i[15];
    end else if (run_q) begin
      if (!st_q[0] && st_q != StLast) begin
        prod_q <= 48'(op_a) * 48'(op_b);
      end
      if (st_q == StLoadU2) begin
        u2_q <= prod_q[32:16];
        p_q  <= Coef9;
      end else if (st_q[0] && st_q != StLast) begin
        p_q <= 31'({1'b0, coef} - prod_q[47:16]);
      end
      if (st_q == StLast) begin
        value_q <= neg_q ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
      end
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("sine unit signaled completion on two cycles in a row");

  a_value_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> value_q != 16'sh8000)
    else $error("sine result escaped the saturated range");

endmodule

`default_nettype wire

// File: rtl/rpm_cell.sv
// One edge cell of the mask chain: holds one edge normal and tests the
// passing pixel against that edge. Depends on rpm_pkg for the chain types.
`default_nettype none

module rpm_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [31:0]       apothem_i,
  input  rpm_pkg::rpm_nrm_t nrm_i,
  output rpm_pkg::rpm_nrm_t nrm_o,
  input  rpm_pkg::rpm_pix_t pix_i,
  output rpm_pkg::rpm_pix_t pix_o
);
  import rpm_pkg::*;

  logic signed [15:0] nx_q;
  logic signed [15:0] ny_q;

  logic               a_vld_q;
  logic               a_in_q;
  logic signed [16:0] a_dx_q;
  logic signed [16:0] a_dy_q;
  logic signed [32:0] a_px_q;
  logic signed [32:0] a_py_q;

  logic               b_vld_q;
  logic               b_in_q;
  logic signed [16:0] b_dx_q;
  logic signed [16:0] b_dy_q;

  logic signed [33:0] dot;
  logic               outside;

  // During a recompute the normals shift one cell down the chain per load strobe.
  always_ff @(posedge clk_i) begin
    if (nrm_i.load) begin
      nx_q <= nrm_i.nx;
      ny_q <= nrm_i.ny;
    end
  end

  assign nrm_o = '{load: nrm_i.load, nx: nx_q, ny: ny_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= pix_i.vld;
      b_vld_q <= a_vld_q;
    end
  end

  assign dot     = 34'(a_px_q) + 34'(a_py_q);
  assign outside = dot > $signed({2'b00, apothem_i});

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_in_q <= pix_i.in_poly;
      a_dx_q <= pix_i.dx;
      a_dy_q <= pix_i.dy;
      a_px_q <= 33'(nx_q) * 33'(pix_i.dx);
      a_py_q <= 33'(ny_q) * 33'(pix_i.dy);
      b_in_q <= a_in_q && !outside;
      b_dx_q <= a_dx_q;
      b_dy_q <= a_dy_q;
    end
  end

  assign pix_o = '{vld: b_vld_q, in_poly: b_in_q, dx: b_dx_q, dy: b_dy_q};

endmodule

`default_nettype wire

// File: rtl/rpm_seq.sv
// Recompute sequencer: derives the edge normals and the apothem from the
// configuration and shifts the normals into the cell chain. Uses rpm_sine.
`default_nettype none

module rpm_seq #(
  parameter int MaxSides = rpm_pkg::MaxSidesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              recalc_i,
  input  logic [15:0]       rotation_i,
  input  logic [15:0]       radius_i,
  input  logic [4:0]        sides_i,
  output logic              busy_o,
  output rpm_pkg::rpm_nrm_t nrm_o,
  output logic [31:0]       apothem_o
);
  import rpm_pkg::*;

  localparam int CW = $clog2(MaxSides + 1);

  // Per side count: 65536 / n, 65536 mod n and the rounded half-step angle.
  logic [15:0]   quo_tab [3:MaxSides];
  logic [CW-1:0] rem_tab [3:MaxSides];
  logic [15:0]   apo_tab [3:MaxSides];

  for (genvar g = 3; g <= MaxSides; g++) begin : g_tab
    localparam int Quo    = 65536 / g;
    localparam int Rem    = 65536 % g;
    localparam int ApoAng = (32768 + g / 2) / g;
    assign quo_tab[g] = 16'(Quo);
    assign rem_tab[g] = CW'(Rem);
    assign apo_tab[g] = 16'(ApoAng);
  end

  seq_state_e state_q, state_d;

  logic [CW-1:0]      k_q;
  logic [CW-1:0]      n_q;
  logic [16:0]        q_q;
  logic [CW-1:0]      r_q;
  logic signed [15:0] cos_q;
  logic [14:0]        cosa_q;
  logic [31:0]        apothem_q;

  logic [CW-1:0]      n_clamp;
  logic [CW:0]        r_sum;
  logic               wrap;
  logic [CW-1:0]      r_next;
  logic [16:0]        q_next;
  logic [15:0]        edge_ang;
  logic               last_edge;
  logic               k_active;

  logic               sine_start;
  logic [15:0]        sine_angle;
  logic               sine_done;
  logic signed [15:0] sine_val;

  always_comb begin
    if (sides_i < 5'd3) begin
      n_clamp = CW'(3);
    end else if (32'(sides_i) > MaxSides) begin
      n_clamp = CW'(MaxSides);
    end else begin
      n_clamp = CW'(sides_i);
    end
  end

  // Rounded step angle round(65536*k/n), advanced by quotient and remainder.
  always_comb begin
    r_sum  = {1'b0, r_q} + {1'b0, rem_tab[n_q]};
    wrap   = r_sum >= {1'b0, n_q};
    r_next = wrap ? CW'(r_sum - {1'b0, n_q}) : CW'(r_sum);
    q_next = q_q + 17'(quo_tab[n_q]) + 17'(wrap);
  end

  assign edge_ang  = rotation_i + q_q[15:0];
  assign last_edge = k_q == CW'(MaxSides);
  assign k_active  = k_q < n_q;

  rpm_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sine_start),
    .angle_i (sine_angle),
    .done_o  (sine_done),
    .value_o (sine_val)
  );

  always_comb begin
    state_d = state_q;
    if (recalc_i) begin
      state_d = SEQ_INIT;
    end else begin
      unique case (state_q)
        SEQ_IDLE: state_d = SEQ_IDLE;
        SEQ_INIT: state_d = SEQ_EDGE;
        SEQ_EDGE: begin
          if (last_edge) begin
            state_d = SEQ_APO;
          end else if (k_active) begin
            state_d = SEQ_COS_WAIT;
          end
        end
        SEQ_COS_WAIT: if (sine_done) state_d = SEQ_SIN_WAIT;
        SEQ_SIN_WAIT: if (sine_done) state_d = SEQ_EDGE;
        SEQ_APO:      state_d = SEQ_APO_WAIT;
        SEQ_APO_WAIT: if (sine_done) state_d = SEQ_APO_MUL;
        SEQ_APO_MUL:  state_d = SEQ_IDLE;
        default:      state_d = SEQ_IDLE;
      endcase
    end
  end

  always_comb begin
    sine_start = 1'b0;
    sine_angle = edge_ang + 16'd16384;
    nrm_o      = '0;
    unique case (state_q)
      SEQ_EDGE: begin
        if (!last_edge) begin
          if (k_active) begin
            sine_start = 1'b1;
          end else begin
            // Unused edges get a zero normal, which never rejects a pixel.
            nrm_o.load = 1'b1;
          end
        end
      end
      SEQ_COS_WAIT: begin
        sine_angle = edge_ang;
        sine_start = sine_done;
      end
      SEQ_SIN_WAIT: begin
        nrm_o.load = sine_done;
        nrm_o.nx   = cos_q;
        nrm_o.ny   = sine_val;
      end
      SEQ_APO: begin
        sine_angle = apo_tab[n_q] + 16'd16384;
        sine_start = 1'b1;
      end
      default: begin
        sine_start = 1'b0;
      end
    endcase
  end

  assign busy_o    = (state_q != SEQ_IDLE) || recalc_i;
  assign apothem_o = apothem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SEQ_INIT: begin
        k_q <= '0;
        n_q <= n_clamp;
        q_q <= '0;
        r_q <= n_clamp >> 1;
      end
      SEQ_EDGE: begin
        if (!last_edge && !k_active) begin
          k_q <= k_q + CW'(1);
        end
      end
      SEQ_COS_WAIT: begin
        if (sine_done) begin
          cos_q <= sine_val;
        end
      end
      SEQ_SIN_WAIT: begin
        if (sine_done) begin
          k_q <= k_q + CW'(1);
          q_q <= q_next;
          r_q <= r_next;
        end
      end
      SEQ_APO_WAIT: begin
        if (sine_done) begin
          cosa_q <= sine_val[14:0];
        end
      end
      SEQ_APO_MUL: begin
        apothem_q <= 32'(radius_i) * 32'(cosa_q);
      end
      default: begin
        cosa_q <= cosa_q;
      end
    endcase
  end

  a_start_spaced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sine_start |=> !sine_start)
    else $error("sine unit restarted on consecutive cycles");

  a_all_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEQ_APO |-> k_q == CW'(MaxSides))
    else $error("apothem step reached before every cell was loaded");

endmodule

`default_nettype wire

// File: rtl/regular_polygon_pixel_mask_top.sv
// Top level of the regular polygon pixel mask: configuration registers,
// input stage, recompute sequencer and the chain of edge cells (rpm_pkg).
//
// The block answers, for every pixel transaction, whether the pixel lies
// inside or on a regular polygon given by center, circumradius, side count
// and rotation. Each pixel travels down a chain of MaxSides edge cells,
// held in the registers of each cell in turn, so one pixel is accepted per
// clock while the sequencer is idle; while a finished result waits at the
// output the whole chain holds and no pixel is accepted. After reset and
// after every register write the sequencer rebuilds the edge normals and the
// apothem with its iterative sine unit (twelve steps, six of them multiplies,
// per sine), and no pixel is accepted meanwhile. The user must write the
// registers only while no pixel is in flight; the block itself does not
// enforce this.
`default_nettype none

module regular_polygon_pixel_mask_top #(
  parameter int MaxSides = rpm_pkg::MaxSidesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,   // column [11:0], row [23:12]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // inside_res [0], zero [7:1]
  input  logic                         cfg_we_i,
  input  logic [rpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rpm_pkg::CfgDataW-1:0] cfg_data_i
);
  import rpm_pkg::*;

  logic [15:0] center_x_q;
  logic [15:0] center_y_q;
  logic [15:0] radius_q;
  logic [4:0]  side_count_q;
  logic [15:0] rotation_q;
  logic        recalc_q;
  logic        cfg_hit;

  logic        busy;
  logic        adv;
  logic [31:0] apothem;

  logic [11:0] column;
  logic [11:0] row;
  logic        in_image;

  logic               f_vld_q;
  logic               f_in_q;
  logic signed [16:0] f_dx_q;
  logic signed [16:0] f_dy_q;

  rpm_pix_t pix_chain [0:MaxSides];
  rpm_nrm_t nrm_chain [0:MaxSides-1];

  always_comb begin
    unique case (cfg_idx_i) inside
      REG_CENTER_X, REG_CENTER_Y, REG_RADIUS, REG_SIDES, REG_ROTATION: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  // Reset starts a recompute so the normals match the reset register values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      radius_q     <= '0;
      side_count_q <= 5'd3;
      rotation_q   <= '0;
      recalc_q     <= 1'b1;
    end else begin
      recalc_q <= cfg_we_i && cfg_hit;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CENTER_X: center_x_q   <= cfg_data_i;
          REG_CENTER_Y: center_y_q   <= cfg_data_i;
          REG_RADIUS:   radius_q     <= cfg_data_i;
          REG_SIDES:    side_count_q <= cfg_data_i[4:0];
          REG_ROTATION: rotation_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  rpm_seq #(
    .MaxSides (MaxSides)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .recalc_i   (recalc_q),
    .rotation_i (rotation_q),
    .radius_i   (radius_q),
    .sides_i    (side_count_q),
    .busy_o     (busy),
    .nrm_o      (nrm_chain[0]),
    .apothem_o  (apothem)
  );

  // The whole chain moves together unless a finished result is stalled.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !busy;

  assign column   = s_axis_tdata[11:0];
  assign row      = s_axis_tdata[23:12];
  assign in_image = ({20'd0, column} < 32'(ImageWidth)) &&
                    ({20'd0, row} < 32'(ImageHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (adv) begin
      f_vld_q <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      f_in_q <= in_image;
      f_dx_q <= $signed({1'b0, column, 4'b0000}) - $signed({1'b0, center_x_q});
      f_dy_q <= $signed({1'b0, row, 4'b0000}) - $signed({1'b0, center_y_q});
    end
  end

  assign pix_chain[0] = '{vld: f_vld_q, in_poly: f_in_q, dx: f_dx_q, dy: f_dy_q};

  for (genvar i = 0; i < MaxSides; i++) begin : g_cell
    if (i == MaxSides - 1) begin : g_last
      rpm_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .adv_i     (adv),
        .apothem_i (apothem),
        .nrm_i     (nrm_chain[i]),
        .nrm_o     (),
        .pix_i     (pix_chain[i]),
        .pix_o     (pix_chain[i+1])
      );
    end else begin : g_mid
      rpm_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .adv_i     (adv),
        .apothem_i (apothem),
        .nrm_i     (nrm_chain[i]),
        .nrm_o     (nrm_chain[i+1]),
        .pix_i     (pix_chain[i]),
        .pix_o     (pix_chain[i+1])
      );
    end
  end

  assign m_axis_tvalid = pix_chain[MaxSides].vld;
  assign m_axis_tdata  = {7'd0, pix_chain[MaxSides].in_poly};

  a_write_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_hit |=> !s_axis_tready)
    else $error("pixel accepted right after a register write");

endmodule

`default_nettype wire
